// ===== rtl/core/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_datapath, ffha_ctrl and first_fit_heap_allocator.
package ffha_pkg;

   localparam int ARENA_GRANULES_DEF = 4096;
   localparam int FIELD_W            = 16;
   localparam int GRANULE_SHIFT      = 3;
   localparam int ROUND_MASK         = (1 << GRANULE_SHIFT) - 1;
   // largest block need: ((65535 + 7) >> 3) + 1 = 8193
   localparam int NEED_W             = 14;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      RD_H,
      RD_N,
      RD_REL
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_SPLIT,
      WR_ALLOC,
      WR_FREE,
      WR_MERGE
   } wr_sel_type;

   typedef enum logic [2:0] {
      H_HOLD,
      H_ZERO,
      H_ADV,
      H_NEXT,
      H_MERGE
   } h_op_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_ALLOC,
      RES_FAIL,
      RES_FREE
   } res_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      h_op_type   h_op;
      logic       lat_h;
      logic       lat_n;
      res_type    res;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_free;
      logic rel_zero;
      logic rel_ok;
      logic h_end;
      logic n_end;
      logic fit;
      logic split;
      logic size_zero;
      logic both_free;
   } dp_stat_type;

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath (which holds ffha_ram).
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_kind, req_request_bytes,
//                                             req_release_offset
//   rsp      out        rsp_valid/rsp_ready   rsp_payload_offset, rsp_granted
//
// After reset a clearing pass writes every header entry with req_ready low.
// One request is worked at a time: an allocate walks the block headers in turn,
// bound by the single header RAM read port and its registered read. A free
// runs a coalescing pass over the blocks, which a zero offset skips.
// A finished result sits in the output register; a stalled rsp side holds
// the next result until it drains.
module first_fit_heap_allocator #(
   parameter int ARENA_GRANULES = ffha_pkg::ARENA_GRANULES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [ffha_pkg::FIELD_W-1:0] req_request_bytes,
   input  logic [ffha_pkg::FIELD_W-1:0] req_release_offset,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ffha_pkg::FIELD_W-1:0] rsp_payload_offset,
   output logic                         rsp_granted
);
   import ffha_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .ARENA_GRANULES (ARENA_GRANULES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_request_bytes  (req_request_bytes),
      .req_release_offset (req_release_offset),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_granted        (rsp_granted)
   );

   // one request in flight: an accepted transfer drops ready next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a failed allocation carries a zero offset
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_payload_offset == '0))
      else $error("failed allocation with nonzero offset");

   // payload offsets are granule aligned
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload_offset[GRANULE_SHIFT-1:0] == '0))
      else $error("payload offset not granule aligned");

   // a new result is only raised from a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while idle");

endmodule

// ===== rtl/core/ffha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module ffha_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ffha_datapath.sv =====
// Allocator datapath: request registers, walk pointer, latched headers,
// header RAM and result registers. Depends on ffha_pkg and ffha_ram.
module ffha_datapath #(
   parameter int ARENA_GRANULES = ffha_pkg::ARENA_GRANULES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ffha_pkg::ctrl_cmd_type       cmd,
   output ffha_pkg::dp_stat_type        stat,
   input  logic                         req_kind,
   input  logic [ffha_pkg::FIELD_W-1:0] req_request_bytes,
   input  logic [ffha_pkg::FIELD_W-1:0] req_release_offset,
   output logic [ffha_pkg::FIELD_W-1:0] rsp_payload_offset,
   output logic                         rsp_granted
);
   import ffha_pkg::*;

   localparam int AW = $clog2(ARENA_GRANULES);
   localparam int SW = $clog2(ARENA_GRANULES + 1);
   localparam int EW = SW + 1;
   localparam int HW = SW + 1;
   localparam int CW = (SW > NEED_W) ? SW : NEED_W;
   localparam int GW = FIELD_W - GRANULE_SHIFT;

   logic              kind_ff;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [FIELD_W-1:0] rel_ff;
   logic [HW-1:0]     h_ff, h_in;
   logic [SW-1:0]     sh_ff, sn_ff;
   logic              th_ff, tn_ff;
   logic [AW-1:0]     clr_ff;
   logic [FIELD_W-1:0] off_ff, off_in;
   logic              granted_ff, granted_in;

   logic [FIELD_W:0]  round_sum;
   logic [GW-1:0]     gidx;
   logic [31:0]       gm1;
   logic [31:0]       split_addr;
   logic [HW-1:0]     n_w;
   logic [CW-1:0]     rem_c;
   logic [SW-1:0]     msum;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [EW-1:0]     wr_data, rd_data;

   assign round_sum  = {1'b0, req_request_bytes} + (FIELD_W + 1)'(ROUND_MASK);
   assign need_in    = NEED_W'(round_sum >> GRANULE_SHIFT) + NEED_W'(1);
   assign gidx       = rel_ff[FIELD_W-1:GRANULE_SHIFT];
   assign gm1        = 32'(gidx) - 32'd1;
   assign split_addr = 32'(h_ff) + 32'(need_ff);
   assign n_w        = h_ff + HW'(sh_ff);
   assign rem_c      = CW'(sh_ff) - CW'(need_ff);
   assign msum       = sh_ff + sn_ff;

   always_comb begin
      stat.clr_last  = (clr_ff == AW'(ARENA_GRANULES - 1));
      stat.is_free   = (kind_ff == KIND_FREE);
      stat.rel_zero  = (rel_ff == '0);
      stat.rel_ok    = (gidx != '0) && (gm1 < 32'(ARENA_GRANULES));
      stat.h_end     = (h_ff >= HW'(ARENA_GRANULES));
      stat.n_end     = (n_w >= HW'(ARENA_GRANULES));
      stat.fit       = !th_ff && (CW'(need_ff) <= CW'(sh_ff));
      stat.split     = (rem_c > CW'(1));
      stat.size_zero = (sh_ff == '0);
      stat.both_free = !th_ff && !tn_ff;
   end

   // header RAM address and data selection
   always_comb begin
      case (cmd.rd_sel)
         RD_H:    rd_addr = h_ff[AW-1:0];
         RD_N:    rd_addr = n_w[AW-1:0];
         RD_REL:  rd_addr = gm1[AW-1:0];
         default: rd_addr = h_ff[AW-1:0];
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = h_ff[AW-1:0];
      wr_data = '0;
      case (cmd.wr_sel)
         WR_CLEAR: begin
            wr_addr = clr_ff;
            wr_data = (clr_ff == '0) ? {SW'(ARENA_GRANULES), 1'b0} : '0;
         end
         WR_SPLIT: begin
            wr_addr = split_addr[AW-1:0];
            wr_data = {rem_c[SW-1:0], 1'b0};
         end
         WR_ALLOC: begin
            wr_data = {(stat.split ? SW'(need_ff) : sh_ff), 1'b1};
         end
         WR_FREE: begin
            wr_addr = gm1[AW-1:0];
            wr_data = {rd_data[EW-1:1], 1'b0};
         end
         WR_MERGE: begin
            wr_data = {msum, 1'b0};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cmd.h_op)
         H_ZERO:  h_in = '0;
         H_ADV:   h_in = n_w;
         H_NEXT:  h_in = n_w;
         H_MERGE: h_in = n_w + HW'(sn_ff);
         default: h_in = h_ff;
      endcase
   end

   always_comb begin
      off_in     = off_ff;
      granted_in = granted_ff;
      case (cmd.res)
         RES_ALLOC: begin
            off_in     = FIELD_W'((32'(h_ff) + 32'd1) << GRANULE_SHIFT);
            granted_in = 1'b1;
         end
         RES_FAIL: begin
            off_in     = '0;
            granted_in = 1'b0;
         end
         RES_FREE: begin
            off_in     = '0;
            granted_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.wr_sel == WR_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         need_ff <= need_in;
         rel_ff  <= req_release_offset;
      end
      h_ff <= h_in;
      if (cmd.lat_h) begin
         sh_ff <= rd_data[EW-1:1];
         th_ff <= rd_data[0];
      end
      if (cmd.lat_n) begin
         sn_ff <= rd_data[EW-1:1];
         tn_ff <= rd_data[0];
      end
      off_ff     <= off_in;
      granted_ff <= granted_in;
   end

   assign rsp_payload_offset = off_ff;
   assign rsp_granted        = granted_ff;

   ffha_ram #(
      .WIDTH (EW),
      .DEPTH (ARENA_GRANULES)
   ) u_header_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== rtl/core/ffha_ctrl.sv =====
// Allocator controller: sequences the clearing pass, allocate walk, free
// and coalescing pass, and owns the handshakes. Depends on ffha_pkg.
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ffha_pkg::dp_stat_type  stat,
   output ffha_pkg::ctrl_cmd_type cmd
);
   import ffha_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_A_RD,
      ST_A_LAT,
      ST_A_DEC,
      ST_A_HDR,
      ST_F_RD,
      ST_F_CLR,
      ST_M_RD_H,
      ST_M_LAT_H,
      ST_M_CHK,
      ST_M_LAT_N,
      ST_M_DEC,
      ST_FIN_ALLOC,
      ST_FIN_FAIL,
      ST_FIN_FREE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_H;
      cmd.wr_sel = WR_NONE;
      cmd.h_op   = H_HOLD;
      cmd.res    = RES_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_sel = WR_CLEAR;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.h_op = H_ZERO;
            if (!stat.is_free) begin
               state_in = ST_A_RD;
            end else if (stat.rel_zero) begin
               state_in = ST_FIN_FREE;
            end else if (stat.rel_ok) begin
               state_in = ST_F_RD;
            end else begin
               state_in = ST_M_RD_H;
            end
         end
         ST_A_RD: begin
            if (stat.h_end) begin
               state_in = ST_FIN_FAIL;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_A_LAT;
            end
         end
         ST_A_LAT: begin
            cmd.lat_h = 1'b1;
            state_in  = ST_A_DEC;
         end
         ST_A_DEC: begin
            if (stat.fit) begin
               // split writes the remainder header first, then the taken one
               if (stat.split) begin
                  cmd.wr_sel = WR_SPLIT;
                  state_in   = ST_A_HDR;
               end else begin
                  cmd.wr_sel = WR_ALLOC;
                  state_in   = ST_FIN_ALLOC;
               end
            end else if (stat.size_zero) begin
               state_in = ST_FIN_FAIL;
            end else begin
               cmd.h_op = H_ADV;
               state_in = ST_A_RD;
            end
         end
         ST_A_HDR: begin
            cmd.wr_sel = WR_ALLOC;
            state_in   = ST_FIN_ALLOC;
         end
         ST_F_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_REL;
            state_in   = ST_F_CLR;
         end
         ST_F_CLR: begin
            cmd.wr_sel = WR_FREE;
            state_in   = ST_M_RD_H;
         end
         ST_M_RD_H: begin
            if (stat.h_end) begin
               state_in = ST_FIN_FREE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_M_LAT_H;
            end
         end
         ST_M_LAT_H: begin
            cmd.lat_h = 1'b1;
            state_in  = ST_M_CHK;
         end
         ST_M_CHK: begin
            if (stat.size_zero || stat.n_end) begin
               state_in = ST_FIN_FREE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_N;
               state_in   = ST_M_LAT_N;
            end
         end
         ST_M_LAT_N: begin
            cmd.lat_n = 1'b1;
            state_in  = ST_M_DEC;
         end
         ST_M_DEC: begin
            if (stat.both_free) begin
               cmd.wr_sel = WR_MERGE;
               cmd.h_op   = H_MERGE;
            end else begin
               cmd.h_op = H_NEXT;
            end
            state_in = ST_M_RD_H;
         end
         ST_FIN_ALLOC: begin
            if (slot_free) begin
               cmd.res  = RES_ALLOC;
               state_in = ST_IDLE;
            end
         end
         ST_FIN_FAIL: begin
            if (slot_free) begin
               cmd.res  = RES_FAIL;
               state_in = ST_IDLE;
            end
         end
         ST_FIN_FREE: begin
            if (slot_free) begin
               cmd.res  = RES_FREE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res != RES_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
